// File: design/invcnt_pkg.sv
// Shared types and constants for the inversion counter.
`timescale 1ns / 1ps
package invcnt_pkg;

    localparam int TOTAL_W = 15;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 15'h7fff;

    // Control bits that travel with a word down the cell chain.
    typedef struct packed {
        logic valid;   // slot holds a word
        logic start;   // word opens a new sequence
        logic stored;  // word already placed in a cell
    } t_tok_ctrl;

endpackage

// File: design/invcnt_cell.sv
// One cell of the chain: holds one stored key and counts greater keys for passing words.
`timescale 1ns / 1ps
module invcnt_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  invcnt_pkg::t_tok_ctrl    i_ctrl,
    input  logic [VALUE_WIDTH-1:0]   i_key,
    input  logic [CNT_W-1:0]         i_cnt,
    output invcnt_pkg::t_tok_ctrl    o_ctrl,
    output logic [VALUE_WIDTH-1:0]   o_key,
    output logic [CNT_W-1:0]         o_cnt
);

    logic                   r_full;
    logic                   n_full;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [VALUE_WIDTH-1:0] n_key;
    invcnt_pkg::t_tok_ctrl  r_ctrl;
    invcnt_pkg::t_tok_ctrl  n_ctrl;
    logic [VALUE_WIDTH-1:0] r_tok_key;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   w_held;

    // A start word empties every cell it passes.
    assign w_held = r_full && !i_ctrl.start;

    always_comb begin
        n_full = r_full;
        n_key  = r_key;
        n_ctrl = i_ctrl;
        n_cnt  = i_cnt;
        if (i_ctrl.valid) begin
            if (w_held && (r_key > i_key)) begin
                n_cnt = i_cnt + CNT_W'(1);
            end
            if (!w_held && !i_ctrl.stored) begin
                n_full        = 1'b1;
                n_key         = i_key;
                n_ctrl.stored = 1'b1;
            end else begin
                n_full = w_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_ctrl <= '0;
        end else if (i_adv) begin
            r_full <= n_full;
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key     <= n_key;
            r_tok_key <= i_key;
            r_cnt     <= n_cnt;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_key  = r_tok_key;
    assign o_cnt  = r_cnt;

endmodule

// File: design/invcnt_acc.sv
// Output stage: running total with saturation, overflow flag and result register.
`timescale 1ns / 1ps
module invcnt_acc #(
    parameter int CNT_W = 9
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_stall,
    input  invcnt_pkg::t_tok_ctrl             i_ctrl,
    input  logic [CNT_W-1:0]                  i_cnt,
    output logic                              o_adv,
    output logic                              o_valid,
    output logic [invcnt_pkg::TOTAL_W-1:0]    o_total,
    output logic                              o_overflow
);

    localparam int SW = (CNT_W > invcnt_pkg::TOTAL_W ? CNT_W : invcnt_pkg::TOTAL_W) + 1;

    logic                           r_valid;
    logic [invcnt_pkg::TOTAL_W-1:0] r_total;
    logic [invcnt_pkg::TOTAL_W-1:0] n_total;
    logic                           r_ovf;
    logic                           n_ovf;
    logic [invcnt_pkg::TOTAL_W-1:0] w_base;
    logic                           w_base_ovf;
    logic [SW-1:0]                  w_sum;

    assign o_adv = !r_valid || !i_stall;

    assign w_base     = i_ctrl.start ? '0 : r_total;
    assign w_base_ovf = i_ctrl.start ? 1'b0 : r_ovf;
    assign w_sum      = SW'(w_base) + SW'(i_cnt);

    always_comb begin
        n_total = r_total;
        n_ovf   = r_ovf;
        if (i_ctrl.valid) begin
            n_total = w_base;
            n_ovf   = w_base_ovf;
            if (i_ctrl.stored) begin
                if (w_sum > SW'(invcnt_pkg::TOTAL_MAX)) begin
                    n_total = invcnt_pkg::TOTAL_MAX;
                end else begin
                    n_total = w_sum[invcnt_pkg::TOTAL_W-1:0];
                end
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_ctrl.valid;
            r_total <= n_total;
            r_ovf   <= n_ovf;
        end
    end

    assign o_valid    = r_valid;
    assign o_total    = r_total;
    assign o_overflow = r_ovf;

endmodule

// File: design/inversion_counter_top.sv
// Top level of the inversion counter: input keying, cell chain and output stage.
//
// Input channel: i_valid / o_stall carry i_value (signed) and i_start_req.
// Output channel: o_valid / i_stall carry o_total and o_overflow, one result
// word for every input word, in order.
// Each word walks a chain of CAPACITY cells, one cell per cycle while the
// chain advances. Each cell holds one stored value; a passing word counts
// the stored values greater than its own and is stored in the first empty
// cell. A start word empties the cells as it passes, so words behind it see
// only the new sequence. Words that find no empty cell set the overflow
// flag and are not counted.
// Throughput: one word per cycle while the output is not stalled; the chain
// holds up to CAPACITY words, plus one in the output register.
// A stalled result word freezes the whole chain and the input stalls with it.
// Reset empties all cells, clears the total, the overflow flag and all
// in-flight words.
`timescale 1ns / 1ps
module inversion_counter_top #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [VALUE_WIDTH-1:0]     i_value,
    input  logic                              i_start_req,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [invcnt_pkg::TOTAL_W-1:0]    o_total,
    output logic                              o_overflow
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                   w_adv;
    invcnt_pkg::t_tok_ctrl  w_ctrl [0:CAPACITY];
    logic [VALUE_WIDTH-1:0] w_key  [0:CAPACITY];
    logic [CNT_W-1:0]       w_cnt  [0:CAPACITY];

    assign o_stall = !w_adv;

    // Flip the sign bit so unsigned order matches signed order.
    assign w_key[0]         = {~i_value[VALUE_WIDTH-1], i_value[VALUE_WIDTH-2:0]};
    assign w_ctrl[0].valid  = i_valid;
    assign w_ctrl[0].start  = i_start_req;
    assign w_ctrl[0].stored = 1'b0;
    assign w_cnt[0]         = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        invcnt_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctrl  (w_ctrl[g]),
            .i_key   (w_key[g]),
            .i_cnt   (w_cnt[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_key   (w_key[g+1]),
            .o_cnt   (w_cnt[g+1])
        );
    end

    invcnt_acc #(
        .CNT_W (CNT_W)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stall    (i_stall),
        .i_ctrl     (w_ctrl[CAPACITY]),
        .i_cnt      (w_cnt[CAPACITY]),
        .o_adv      (w_adv),
        .o_valid    (o_valid),
        .o_total    (o_total),
        .o_overflow (o_overflow)
    );

endmodule
